>>> design/complex_arithmetic_unit_defines.svh
// assertion macros shared by the checkers of the complex arithmetic unit
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication, off while reset is high
`define CAU_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define CAU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// what must hold in the cycle after reset
`define CAU_ASSERT_RESET(label, cons, msg) \
   label: assert property (@(posedge clock) reset |=> (cons)) else $error(msg);

`endif

>>> design/cau_pkg.sv
package cau_pkg;

   // operand format
   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 12;
   localparam int OP_W       = 3;

   // product, sum and clip widths
   localparam int PROD_W = 2 * DATA_WIDTH;
   localparam int SUM_W  = PROD_W + 1;
   localparam int MAG_W  = PROD_W;
   localparam int D_W    = PROD_W;
   localparam int CLIP_W = PROD_W + 4;

   // division: quotient bits kept before saturation, numerator bits shifted in
   localparam int Q_W       = DATA_WIDTH + 1;
   localparam int DIV_STEPS = Q_W;
   localparam int NUM_LO_W  = Q_W - FRAC_BITS;
   localparam int OVF_W     = D_W + NUM_LO_W;

   // square root
   localparam int SQ_W       = PROD_W;
   localparam int SQRT_STEPS = DATA_WIDTH;
   localparam logic [SQ_W-1:0] SQ_BIT0 = SQ_W'(1) << (2 * DATA_WIDTH - 2);

   // vectoring rotation
   localparam int ANG_BITS   = 30;
   localparam int CELLS      = 30;
   localparam int PRESCALE   = 24;
   localparam int CX_W       = DATA_WIDTH + PRESCALE + 4;
   localparam int CZ_W       = ANG_BITS + 4;
   localparam int ANG_SHIFT  = ANG_BITS - FRAC_BITS;
   localparam int CELL_IDX_W = $clog2(CELLS);

   localparam logic signed [CZ_W-1:0] PI_Q30 = CZ_W'(33'd3373259426);
   localparam logic signed [CZ_W-1:0] ANG_HALF = CZ_W'(1) << (ANG_SHIFT - 1);
   localparam logic signed [CLIP_W-1:0] MUL_HALF = CLIP_W'(1) << (FRAC_BITS - 1);

   localparam logic [ANG_BITS-1:0] ATAN_Q30 [CELLS] = '{
      30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
      30'd33543515,  30'd16775850,  30'd8388437,   30'd4194282,   30'd2097149,
      30'd1048575,   30'd524287,    30'd262143,    30'd131071,    30'd65535,
      30'd32767,     30'd16383,     30'd8191,      30'd4095,      30'd2047,
      30'd1023,      30'd511,       30'd255,       30'd127,       30'd63,
      30'd31,        30'd15,        30'd7,         30'd3,         30'd1
   };

   // saturation bounds
   localparam logic signed [CLIP_W-1:0] CLIP_HI =
      {{(CLIP_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [CLIP_W-1:0] CLIP_LO =
      {{(CLIP_W-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

   typedef enum logic [OP_W-1:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_MOD = 3'd4,
      OP_ARG = 3'd5
   } op_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] val;
      logic                         sat;
   } clip_type;

   // everything one item carries along the cell row
   typedef struct packed {
      logic [OP_W-1:0]              op;
      logic signed [DATA_WIDTH-1:0] pre_re;
      logic signed [DATA_WIDTH-1:0] pre_im;
      logic                         pre_sat;
      logic                         pre_dz;
      logic [D_W-1:0]               div_d;
      logic                         neg_re;
      logic                         neg_im;
      logic                         ovf_re;
      logic                         ovf_im;
      logic [D_W-1:0]               rem_re;
      logic [D_W-1:0]               rem_im;
      logic [NUM_LO_W-1:0]          nlo_re;
      logic [NUM_LO_W-1:0]          nlo_im;
      logic [Q_W-1:0]               q_re;
      logic [Q_W-1:0]               q_im;
      logic [SQ_W-1:0]              sq_n;
      logic [SQ_W-1:0]              sq_res;
      logic [SQ_W-1:0]              sq_bit;
      logic signed [CX_W-1:0]       cx;
      logic signed [CX_W-1:0]       cy;
      logic signed [CZ_W-1:0]       cz;
      logic                         axis;
      logic                         axis_neg;
   } cell_data_type;

   // clip a wide signed value to the output range
   function automatic clip_type clip_val(input logic signed [CLIP_W-1:0] v);
      clip_type r;
      r.val = v[DATA_WIDTH-1:0];
      r.sat = 1'b0;
      if (v > CLIP_HI) begin
         r.val = CLIP_HI[DATA_WIDTH-1:0];
         r.sat = 1'b1;
      end else if (v < CLIP_LO) begin
         r.val = CLIP_LO[DATA_WIDTH-1:0];
         r.sat = 1'b1;
      end
      return r;
   endfunction

endpackage

>>> design/cau_if.sv
// operation request channel
interface cau_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [cau_pkg::OP_W-1:0]             op;
   logic signed [cau_pkg::DATA_WIDTH-1:0] a_re;
   logic signed [cau_pkg::DATA_WIDTH-1:0] a_im;
   logic signed [cau_pkg::DATA_WIDTH-1:0] b_re;
   logic signed [cau_pkg::DATA_WIDTH-1:0] b_im;

   modport source (output valid, op, a_re, a_im, b_re, b_im, input ready);
   modport sink (input valid, op, a_re, a_im, b_re, b_im, output ready);
endinterface

// result channel
interface cau_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [cau_pkg::DATA_WIDTH-1:0] result_re;
   logic signed [cau_pkg::DATA_WIDTH-1:0] result_im;
   logic                                 saturated;
   logic                                 div_by_zero;

   modport source (output valid, result_re, result_im, saturated, div_by_zero, input ready);
   modport sink (input valid, result_re, result_im, saturated, div_by_zero, output ready);
endinterface

>>> design/complex_arithmetic_unit.sv
// Complex arithmetic unit, Q3.12 fixed point.
// req_chan carries an operation code and two complex operands; rsp_chan
// returns the complex result with saturated and div_by_zero flags. Both are
// valid/ready channels: a transfer happens on a clock edge with both high.
// Operations: add, subtract, multiply, divide, modulus and argument; modulus
// and argument come back in the real part with a zero imaginary part.
// The response passes through 34 register stages: three front stages
// (products, sums, divide setup), a row of 30 cells and one output stage.
// Each cell does one rotation; the first 17 cells also do one restoring
// quotient bit and the first 16 one root bit. Throughput is one operation
// per cycle while the receiver is ready, set by the cell row taking a new
// item every cycle. Every stage has its own valid bit and loads when it is
// empty or its successor loads, so a stalled receiver only blocks the full
// stages behind the output register; bubbles ahead of it still fill.
// Reset is synchronous and clears all valid bits; no result is pending after.
module complex_arithmetic_unit (
   input logic       clock,
   input logic       reset,
   cau_req_if.sink   req_chan,
   cau_rsp_if.source rsp_chan
);

   logic                   link_vld  [cau_pkg::CELLS+1];
   logic                   link_load [cau_pkg::CELLS+1];
   cau_pkg::cell_data_type link_data [cau_pkg::CELLS+1];

   // operand products and setup
   cau_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .out_vld  (link_vld[0]),
      .out_data (link_data[0]),
      .out_load (link_load[0])
   );

   // row of step cells
   for (genvar k = 0; k < cau_pkg::CELLS; k++) begin : g_cell
      cau_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .idx      (cau_pkg::CELL_IDX_W'(k)),
         .in_vld   (link_vld[k]),
         .in_data  (link_data[k]),
         .in_load  (link_load[k]),
         .out_load (link_load[k+1]),
         .out_vld  (link_vld[k+1]),
         .out_data (link_data[k+1])
      );
   end

   // rounding, saturation and output register
   cau_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (link_vld[cau_pkg::CELLS]),
      .in_data  (link_data[cau_pkg::CELLS]),
      .in_load  (link_load[cau_pkg::CELLS]),
      .rsp_chan (rsp_chan)
   );

endmodule

>>> design/cau_front.sv
module cau_front (
   input  logic                   clock,
   input  logic                   reset,
   cau_req_if.sink                req_chan,
   output logic                   out_vld,
   output cau_pkg::cell_data_type out_data,
   input  logic                   out_load
);

   localparam int DW = cau_pkg::DATA_WIDTH;
   localparam int PW = cau_pkg::PROD_W;
   localparam int CW = cau_pkg::CLIP_W;
   localparam int XW = cau_pkg::CX_W;
   localparam int D_W_LOCAL = cau_pkg::D_W;

   // stage a: operands and products
   logic                          a_vld_ff;
   logic [cau_pkg::OP_W-1:0]      a_op_ff;
   logic signed [DW-1:0]          a_ar_ff, a_ai_ff, a_br_ff, a_bi_ff;
   logic signed [PW-1:0]          a_rr_ff, a_ii_ff, a_ri_ff, a_ir_ff, a_s0_ff, a_s1_ff;
   logic signed [PW-1:0]          a_rr_in, a_ii_in, a_ri_in, a_ir_in, a_s0_in, a_s1_in;
   logic signed [DW-1:0]          sq_m0, sq_m1;
   logic                          load_a, load_b, load_c;

   // stage b: closed-form results and setup
   logic                          b_vld_ff;
   cau_pkg::cell_data_type        b_data_ff, b_data_in;
   logic signed [cau_pkg::SUM_W-1:0] b_num_re_ff, b_num_im_ff, b_num_re_in, b_num_im_in;

   // stage c: division setup
   logic                          c_vld_ff;
   cau_pkg::cell_data_type        c_data_ff, c_data_in;

   logic signed [CW-1:0]          add_re, add_im, sub_re, sub_im;
   logic signed [CW-1:0]          mul_dre, mul_dim, mul_re, mul_im;
   logic [D_W_LOCAL-1:0]          sq_sum;
   logic signed [XW-1:0]          x0, y0;
   cau_pkg::clip_type             cl_re, cl_im;
   logic [cau_pkg::SUM_W-1:0]     mag_re_w, mag_im_w;
   logic [cau_pkg::MAG_W-1:0]     mag_re, mag_im;

   assign load_c = !c_vld_ff || out_load;
   assign load_b = !b_vld_ff || load_c;
   assign load_a = !a_vld_ff || load_b;
   assign req_chan.ready = load_a;

   // squares: divisor for divide, operand for modulus
   assign sq_m0 = (cau_pkg::op_type'(req_chan.op) == cau_pkg::OP_MOD) ? req_chan.a_re
                                                                      : req_chan.b_re;
   assign sq_m1 = (cau_pkg::op_type'(req_chan.op) == cau_pkg::OP_MOD) ? req_chan.a_im
                                                                      : req_chan.b_im;
   assign a_rr_in = req_chan.a_re * req_chan.b_re;
   assign a_ii_in = req_chan.a_im * req_chan.b_im;
   assign a_ri_in = req_chan.a_re * req_chan.b_im;
   assign a_ir_in = req_chan.a_im * req_chan.b_re;
   assign a_s0_in = sq_m0 * sq_m0;
   assign a_s1_in = sq_m1 * sq_m1;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else begin
         if (load_a) a_vld_ff <= req_chan.valid;
         if (load_b) b_vld_ff <= a_vld_ff;
         if (load_c) c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load_a) begin
         a_op_ff <= req_chan.op;
         a_ar_ff <= req_chan.a_re;
         a_ai_ff <= req_chan.a_im;
         a_br_ff <= req_chan.b_re;
         a_bi_ff <= req_chan.b_im;
         a_rr_ff <= a_rr_in;
         a_ii_ff <= a_ii_in;
         a_ri_ff <= a_ri_in;
         a_ir_ff <= a_ir_in;
         a_s0_ff <= a_s0_in;
         a_s1_ff <= a_s1_in;
      end
      if (load_b) begin
         b_data_ff   <= b_data_in;
         b_num_re_ff <= b_num_re_in;
         b_num_im_ff <= b_num_im_in;
      end
      if (load_c) c_data_ff <= c_data_in;
   end

   // add, subtract and multiply close here
   assign add_re = {{(CW-DW){a_ar_ff[DW-1]}}, a_ar_ff} + {{(CW-DW){a_br_ff[DW-1]}}, a_br_ff};
   assign add_im = {{(CW-DW){a_ai_ff[DW-1]}}, a_ai_ff} + {{(CW-DW){a_bi_ff[DW-1]}}, a_bi_ff};
   assign sub_re = {{(CW-DW){a_ar_ff[DW-1]}}, a_ar_ff} - {{(CW-DW){a_br_ff[DW-1]}}, a_br_ff};
   assign sub_im = {{(CW-DW){a_ai_ff[DW-1]}}, a_ai_ff} - {{(CW-DW){a_bi_ff[DW-1]}}, a_bi_ff};
   assign mul_dre = {{(CW-PW){a_rr_ff[PW-1]}}, a_rr_ff} - {{(CW-PW){a_ii_ff[PW-1]}}, a_ii_ff};
   assign mul_dim = {{(CW-PW){a_ri_ff[PW-1]}}, a_ri_ff} + {{(CW-PW){a_ir_ff[PW-1]}}, a_ir_ff};
   assign mul_re = (mul_dre + cau_pkg::MUL_HALF) >>> cau_pkg::FRAC_BITS;
   assign mul_im = (mul_dim + cau_pkg::MUL_HALF) >>> cau_pkg::FRAC_BITS;

   // sum of squares and divide numerators
   assign sq_sum = D_W_LOCAL'($unsigned(a_s0_ff)) + D_W_LOCAL'($unsigned(a_s1_ff));
   assign b_num_re_in = {a_rr_ff[PW-1], a_rr_ff} + {a_ii_ff[PW-1], a_ii_ff};
   assign b_num_im_in = {a_ir_ff[PW-1], a_ir_ff} - {a_ri_ff[PW-1], a_ri_ff};

   // scaled start vector for the rotation
   assign x0 = {{(XW-DW-cau_pkg::PRESCALE){a_ar_ff[DW-1]}}, a_ar_ff, {cau_pkg::PRESCALE{1'b0}}};
   assign y0 = {{(XW-DW-cau_pkg::PRESCALE){a_ai_ff[DW-1]}}, a_ai_ff, {cau_pkg::PRESCALE{1'b0}}};

   always_comb begin
      b_data_in = '0;
      b_data_in.op = a_op_ff;
      b_data_in.div_d = sq_sum;
      b_data_in.sq_n = sq_sum;
      b_data_in.sq_bit = cau_pkg::SQ_BIT0;
      b_data_in.axis = (a_ai_ff == '0);
      b_data_in.axis_neg = a_ar_ff[DW-1];
      cl_re = '0;
      cl_im = '0;
      // left half-plane starts rotated by a half turn
      if (a_ar_ff[DW-1]) begin
         b_data_in.cx = -x0;
         b_data_in.cy = -y0;
         b_data_in.cz = (!a_ai_ff[DW-1] && (a_ai_ff != '0)) ? cau_pkg::PI_Q30
                                                             : -cau_pkg::PI_Q30;
      end else begin
         b_data_in.cx = x0;
         b_data_in.cy = y0;
      end
      unique case (cau_pkg::op_type'(a_op_ff))
         cau_pkg::OP_ADD: begin
            cl_re = cau_pkg::clip_val(add_re);
            cl_im = cau_pkg::clip_val(add_im);
         end
         cau_pkg::OP_SUB: begin
            cl_re = cau_pkg::clip_val(sub_re);
            cl_im = cau_pkg::clip_val(sub_im);
         end
         cau_pkg::OP_MUL: begin
            cl_re = cau_pkg::clip_val(mul_re);
            cl_im = cau_pkg::clip_val(mul_im);
         end
         cau_pkg::OP_DIV: begin
            b_data_in.pre_dz = (sq_sum == '0);
         end
         default: begin
         end
      endcase
      b_data_in.pre_re = cl_re.val;
      b_data_in.pre_im = cl_im.val;
      b_data_in.pre_sat = cl_re.sat | cl_im.sat;
   end

   // numerator magnitudes, overflow test and first partial remainders
   assign mag_re_w = b_num_re_ff[cau_pkg::SUM_W-1] ? -b_num_re_ff : b_num_re_ff;
   assign mag_im_w = b_num_im_ff[cau_pkg::SUM_W-1] ? -b_num_im_ff : b_num_im_ff;
   assign mag_re = mag_re_w[cau_pkg::MAG_W-1:0];
   assign mag_im = mag_im_w[cau_pkg::MAG_W-1:0];

   always_comb begin
      c_data_in = b_data_ff;
      c_data_in.neg_re = b_num_re_ff[cau_pkg::SUM_W-1];
      c_data_in.neg_im = b_num_im_ff[cau_pkg::SUM_W-1];
      c_data_in.ovf_re = cau_pkg::OVF_W'(mag_re) >= {b_data_ff.div_d, {cau_pkg::NUM_LO_W{1'b0}}};
      c_data_in.ovf_im = cau_pkg::OVF_W'(mag_im) >= {b_data_ff.div_d, {cau_pkg::NUM_LO_W{1'b0}}};
      c_data_in.rem_re = D_W_LOCAL'(mag_re >> cau_pkg::NUM_LO_W);
      c_data_in.rem_im = D_W_LOCAL'(mag_im >> cau_pkg::NUM_LO_W);
      c_data_in.nlo_re = mag_re[cau_pkg::NUM_LO_W-1:0];
      c_data_in.nlo_im = mag_im[cau_pkg::NUM_LO_W-1:0];
      c_data_in.q_re = '0;
      c_data_in.q_im = '0;
   end

   assign out_vld = c_vld_ff;
   assign out_data = c_data_ff;

endmodule

>>> design/cau_cell.sv
module cau_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [cau_pkg::CELL_IDX_W-1:0] idx,
   input  logic                           in_vld,
   input  cau_pkg::cell_data_type         in_data,
   output logic                           in_load,
   input  logic                           out_load,
   output logic                           out_vld,
   output cau_pkg::cell_data_type         out_data
);

   localparam int DW = cau_pkg::D_W;
   localparam int XW = cau_pkg::CX_W;
   localparam int ZW = cau_pkg::CZ_W;

   logic                   vld_ff;
   cau_pkg::cell_data_type data_ff, data_in;

   logic [DW:0]            dre_t, dim_t;
   logic                   dre_take, dim_take;
   logic [cau_pkg::SQ_W:0] sq_trial;
   logic                   sq_take;
   logic signed [XW-1:0]   cx_s, cy_s, dx, dy;
   logic signed [ZW-1:0]   cz_s, atan_s;
   logic                   rot_pos;

   assign in_load = !vld_ff || out_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_load) begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) data_ff <= data_in;
   end

   // one restoring quotient bit for each divide lane
   assign dre_t = {in_data.rem_re, in_data.nlo_re[cau_pkg::NUM_LO_W-1]};
   assign dim_t = {in_data.rem_im, in_data.nlo_im[cau_pkg::NUM_LO_W-1]};
   assign dre_take = dre_t >= {1'b0, in_data.div_d};
   assign dim_take = dim_t >= {1'b0, in_data.div_d};

   // one root bit
   assign sq_trial = {1'b0, in_data.sq_res} + {1'b0, in_data.sq_bit};
   assign sq_take = {1'b0, in_data.sq_n} >= sq_trial;

   // one micro-rotation
   assign cx_s = in_data.cx;
   assign cy_s = in_data.cy;
   assign cz_s = in_data.cz;
   assign dx = cy_s >>> idx;
   assign dy = cx_s >>> idx;
   assign atan_s = $signed({{(ZW-cau_pkg::ANG_BITS){1'b0}}, cau_pkg::ATAN_Q30[idx]});
   assign rot_pos = !cy_s[XW-1] && (cy_s != '0);

   always_comb begin
      data_in = in_data;
      if (idx < cau_pkg::CELL_IDX_W'(cau_pkg::DIV_STEPS)) begin
         data_in.rem_re = dre_take ? DW'(dre_t - {1'b0, in_data.div_d}) : dre_t[DW-1:0];
         data_in.rem_im = dim_take ? DW'(dim_t - {1'b0, in_data.div_d}) : dim_t[DW-1:0];
         data_in.q_re = {in_data.q_re[cau_pkg::Q_W-2:0], dre_take};
         data_in.q_im = {in_data.q_im[cau_pkg::Q_W-2:0], dim_take};
         data_in.nlo_re = in_data.nlo_re << 1;
         data_in.nlo_im = in_data.nlo_im << 1;
      end
      if (idx < cau_pkg::CELL_IDX_W'(cau_pkg::SQRT_STEPS)) begin
         if (sq_take) begin
            data_in.sq_n = in_data.sq_n - sq_trial[cau_pkg::SQ_W-1:0];
            data_in.sq_res = (in_data.sq_res >> 1) + in_data.sq_bit;
         end else begin
            data_in.sq_res = in_data.sq_res >> 1;
         end
         data_in.sq_bit = in_data.sq_bit >> 2;
      end
      if (rot_pos) begin
         data_in.cx = cx_s + dx;
         data_in.cy = cy_s - dy;
         data_in.cz = cz_s + atan_s;
      end else begin
         data_in.cx = cx_s - dx;
         data_in.cy = cy_s + dy;
         data_in.cz = cz_s - atan_s;
      end
   end

   assign out_vld = vld_ff;
   assign out_data = data_ff;

endmodule

>>> design/cau_back.sv
module cau_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_vld,
   input  cau_pkg::cell_data_type in_data,
   output logic                   in_load,
   cau_rsp_if.source              rsp_chan
);

   localparam int DW = cau_pkg::DATA_WIDTH;
   localparam int CW = cau_pkg::CLIP_W;
   localparam int QW = cau_pkg::Q_W;
   localparam int ZW = cau_pkg::CZ_W;
   localparam int SW = cau_pkg::SQ_W;

   logic                 vld_ff;
   logic signed [DW-1:0] re_ff, im_ff, re_in, im_in;
   logic                 sat_ff, dz_ff, sat_in, dz_in;

   logic                 rb_re, rb_im;
   logic [QW:0]          qe_re, qe_im;
   logic signed [CW-1:0] dv_re, dv_im, md_v, ag_v;
   logic [SW:0]          md_r;
   logic signed [ZW-1:0] z_sel, z_rnd;
   cau_pkg::clip_type    cl_re, cl_im;

   assign in_load = !vld_ff || rsp_chan.ready;

   // rounded quotients, overflow forced past the clip bound
   assign rb_re = {in_data.rem_re, 1'b0} >= {1'b0, in_data.div_d};
   assign rb_im = {in_data.rem_im, 1'b0} >= {1'b0, in_data.div_d};
   assign qe_re = in_data.ovf_re ? ((QW+1)'(1) << QW) : ({1'b0, in_data.q_re} + (QW+1)'(rb_re));
   assign qe_im = in_data.ovf_im ? ((QW+1)'(1) << QW) : ({1'b0, in_data.q_im} + (QW+1)'(rb_im));
   assign dv_re = in_data.neg_re ? -$signed({{(CW-QW-1){1'b0}}, qe_re})
                                 : $signed({{(CW-QW-1){1'b0}}, qe_re});
   assign dv_im = in_data.neg_im ? -$signed({{(CW-QW-1){1'b0}}, qe_im})
                                 : $signed({{(CW-QW-1){1'b0}}, qe_im});

   // root rounded to nearest
   assign md_r = {1'b0, in_data.sq_res} + (SW+1)'(in_data.sq_n > in_data.sq_res);
   assign md_v = $signed({{(CW-SW-1){1'b0}}, md_r});

   // angle, real axis handled apart
   assign z_sel = in_data.axis ? (in_data.axis_neg ? cau_pkg::PI_Q30 : '0) : in_data.cz;
   assign z_rnd = (z_sel + cau_pkg::ANG_HALF) >>> cau_pkg::ANG_SHIFT;
   assign ag_v = {{(CW-ZW){z_rnd[ZW-1]}}, z_rnd};

   always_comb begin
      re_in = in_data.pre_re;
      im_in = in_data.pre_im;
      sat_in = in_data.pre_sat;
      dz_in = 1'b0;
      cl_re = '0;
      cl_im = '0;
      unique case (cau_pkg::op_type'(in_data.op))
         cau_pkg::OP_DIV: begin
            if (in_data.pre_dz) begin
               re_in = '0;
               im_in = '0;
               sat_in = 1'b0;
               dz_in = 1'b1;
            end else begin
               cl_re = cau_pkg::clip_val(dv_re);
               cl_im = cau_pkg::clip_val(dv_im);
               re_in = cl_re.val;
               im_in = cl_im.val;
               sat_in = cl_re.sat | cl_im.sat;
            end
         end
         cau_pkg::OP_MOD: begin
            cl_re = cau_pkg::clip_val(md_v);
            re_in = cl_re.val;
            im_in = '0;
            sat_in = cl_re.sat;
         end
         cau_pkg::OP_ARG: begin
            cl_re = cau_pkg::clip_val(ag_v);
            re_in = cl_re.val;
            im_in = '0;
            sat_in = cl_re.sat;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_load) begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         re_ff <= re_in;
         im_ff <= im_in;
         sat_ff <= sat_in;
         dz_ff <= dz_in;
      end
   end

   assign rsp_chan.valid = vld_ff;
   assign rsp_chan.result_re = re_ff;
   assign rsp_chan.result_im = im_ff;
   assign rsp_chan.saturated = sat_ff;
   assign rsp_chan.div_by_zero = dz_ff;

endmodule

>>> design/cau_checker.sv
`include "complex_arithmetic_unit_defines.svh"

module cau_port_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [cau_pkg::DATA_WIDTH-1:0] rsp_re,
   input logic signed [cau_pkg::DATA_WIDTH-1:0] rsp_im,
   input logic                                 rsp_sat,
   input logic                                 rsp_dz
);

   // a pending result stays until its transfer
   `CAU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

   // a pending result keeps its payload
   `CAU_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_re) && $stable(rsp_im) && $stable(rsp_sat) && $stable(rsp_dz), "response changed while stalled")

   // zero divisor gives zero and no clipping
   `CAU_ASSERT_NOW(a_dz_zero, rsp_valid && rsp_dz, rsp_re == '0 && rsp_im == '0 && !rsp_sat, "zero divisor result not zero")

   // with an empty output the whole pipe can advance
   `CAU_ASSERT_NOW(a_ready_free, !rsp_valid, req_ready, "request stalled with empty output")

   // nothing pending after reset
   `CAU_ASSERT_RESET(a_reset_empty, !rsp_valid, "response valid after reset")

endmodule

bind complex_arithmetic_unit cau_port_checker u_cau_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_re    (rsp_chan.result_re),
   .rsp_im    (rsp_chan.result_im),
   .rsp_sat   (rsp_chan.saturated),
   .rsp_dz    (rsp_chan.div_by_zero)
);

>>> dv/cau_checker.sv
// watches both channels of the complex arithmetic unit, predicts each result
// and compares it with what comes back
module cau_checker
   import cau_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   cau_req_if    req,
   cau_rsp_if    rsp,
   output int    fail_count,
   output int    pending,
   output int    checked_count,
   output int    sat_count,
   output int    dz_count
);

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] re;
      logic signed [DATA_WIDTH-1:0] im;
      logic                         sat;
      logic                         dz;
   } cplx_result_t;

   localparam longint ANGLE_PI = 64'sd3373259426;
   localparam longint ARCTAN_TBL [30] = '{
      843314856, 497837829, 263043836, 133525158, 67021686,
      33543515, 16775850, 8388437, 4194282, 2097149,
      1048575, 524287, 262143, 131071, 65535,
      32767, 16383, 8191, 4095, 2047,
      1023, 511, 255, 127, 63,
      31, 15, 7, 3, 1
   };

   cplx_result_t expected_results [$];

   // clip to the signed output range
   function automatic longint saturate(input longint v, inout bit sat);
      longint hi, lo;
      hi = (64'sd1 <<< (DATA_WIDTH - 1)) - 1;
      lo = -(64'sd1 <<< (DATA_WIDTH - 1));
      if (v > hi) begin
         sat = 1'b1;
         return hi;
      end
      if (v < lo) begin
         sat = 1'b1;
         return lo;
      end
      return v;
   endfunction

   function automatic longint round_down_shift(input longint v, input int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   // signed magnitude split of a product sum, modulo 2^64
   function automatic void split_sign(input longint unsigned u, output bit neg,
                                      output longint unsigned mag);
      if (u <= (64'd1 << 63)) begin
         neg = 1'b0;
         mag = u;
      end else begin
         neg = 1'b1;
         mag = 64'd0 - u;
      end
   endfunction

   // rounded fixed-point quotient, capped at 2^40
   function automatic longint frac_quotient(input bit neg, input longint unsigned u,
                                            input longint unsigned d);
      longint unsigned cap, q, r, r2;
      cap = 64'd1 << 40;
      q = u / d;
      r = u % d;
      if (q > cap) q = cap;
      else begin
         for (int i = 0; i < FRAC_BITS; i++) begin
            r2 = r * 2;
            q = q * 2;
            if (r2 >= d) begin
               q++;
               r2 -= d;
            end
            r = r2;
            if (q > cap) begin
               q = cap;
               break;
            end
         end
         if (q < cap && r * 2 >= d) q++;
      end
      return neg ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint unsigned nearest_root(input longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b;
            res = (res >> 1) + b;
         end else res >>= 1;
         b >>= 2;
      end
      if (n > res) res++;
      return res;
   endfunction

   // vectoring rotation, angle in Q30
   function automatic longint phase_q30(input longint x0, input longint y0);
      longint x, y, z, dx, dy;
      z = 0;
      if (y0 == 0) return (x0 < 0) ? ANGLE_PI : 0;
      x = x0 <<< 24;
      y = y0 <<< 24;
      if (x < 0) begin
         z = (y > 0) ? ANGLE_PI : -ANGLE_PI;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < 30; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx;
            y -= dy;
            z += ARCTAN_TBL[i];
         end else begin
            x -= dx;
            y += dy;
            z -= ARCTAN_TBL[i];
         end
      end
      return z;
   endfunction

   function automatic cplx_result_t compute_result(input logic [OP_W-1:0] op,
      input longint ar, input longint ai, input longint br, input longint bi);
      cplx_result_t r;
      longint rr, ri;
      longint unsigned d, mag;
      bit sat, neg;
      rr = 0;
      ri = 0;
      sat = 0;
      r.dz = 0;
      case (op)
         OP_ADD: begin
            rr = saturate(ar + br, sat);
            ri = saturate(ai + bi, sat);
         end
         OP_SUB: begin
            rr = saturate(ar - br, sat);
            ri = saturate(ai - bi, sat);
         end
         OP_MUL: begin
            rr = saturate(round_down_shift(ar * br - ai * bi, FRAC_BITS), sat);
            ri = saturate(round_down_shift(ar * bi + ai * br, FRAC_BITS), sat);
         end
         OP_DIV: begin
            d = longint'(br * br) + longint'(bi * bi);
            if (d == 0) r.dz = 1'b1;
            else begin
               split_sign(ar * br + ai * bi, neg, mag);
               rr = saturate(frac_quotient(neg, mag, d), sat);
               split_sign(ai * br - ar * bi, neg, mag);
               ri = saturate(frac_quotient(neg, mag, d), sat);
            end
         end
         OP_MOD: begin
            d = ar * ar + ai * ai;
            rr = saturate(longint'(nearest_root(d)), sat);
         end
         OP_ARG: rr = saturate(round_down_shift(phase_q30(ar, ai), 18), sat);
         default: ;
      endcase
      r.re = rr[DATA_WIDTH-1:0];
      r.im = ri[DATA_WIDTH-1:0];
      r.sat = sat;
      return r;
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   assign pending = expected_results.size();

   initial begin
      fail_count = 0;
      checked_count = 0;
      sat_count = 0;
      dz_count = 0;
   end

   // request transfer: queue the prediction
   always @(posedge clock) begin
      if (!reset && req.valid && req.ready)
         expected_results.push_back(compute_result(req.op, longint'(req.a_re),
            longint'(req.a_im), longint'(req.b_re), longint'(req.b_im)));
   end

   // response transfer: compare with the oldest prediction
   always @(posedge clock) begin
      cplx_result_t want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_results.size() == 0) report("unexpected result", 0, 0);
         else begin
            want = expected_results.pop_front();
            checked_count++;
            if (want.sat) sat_count++;
            if (want.dz) dz_count++;
            if (rsp.result_re !== want.re) report("result_re", rsp.result_re, want.re);
            if (rsp.result_im !== want.im) report("result_im", rsp.result_im, want.im);
            if (rsp.saturated !== want.sat) report("saturated", rsp.saturated, want.sat);
            if (rsp.div_by_zero !== want.dz) report("div_by_zero", rsp.div_by_zero, want.dz);
         end
      end
   end

endmodule

>>> dv/testbench.sv
module testbench;
   import cau_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
   localparam logic signed [DATA_WIDTH-1:0] VMAX = 16'sh7fff;
   localparam logic signed [DATA_WIDTH-1:0] VMIN = 16'sh8000;

   logic clock;
   logic reset;
   int   fail_count, pending, checked_count, sat_count, dz_count;
   bit   sending_done;

   cau_req_if req_chan ();
   cau_rsp_if rsp_chan ();

   complex_arithmetic_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   cau_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req           (req_chan),
      .rsp           (rsp_chan),
      .fail_count    (fail_count),
      .pending       (pending),
      .checked_count (checked_count),
      .sat_count     (sat_count),
      .dz_count      (dz_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_len();
      int k;
      k = $urandom_range(0, 19);
      if (k < 12) return 0;
      if (k < 18) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [DATA_WIDTH-1:0] pick_operand();
      case ($urandom_range(0, 5))
         0: case ($urandom_range(0, 4))
               0: return VMAX;
               1: return VMIN;
               2: return 16'sd0;
               3: return -16'sd1;
               default: return 16'sd1;
            endcase
         1, 2: return 16'($signed($urandom_range(0, 16384)) - 8192);
         3: return 16'($signed($urandom_range(0, 64)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   // one request transfer; valid stays high across back-to-back items
   task automatic send(input logic [OP_W-1:0] op, input logic signed [DATA_WIDTH-1:0] ar,
                       input logic signed [DATA_WIDTH-1:0] ai,
                       input logic signed [DATA_WIDTH-1:0] br,
                       input logic signed [DATA_WIDTH-1:0] bi);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.op    <= op;
      req_chan.a_re  <= ar;
      req_chan.a_im  <= ai;
      req_chan.b_re  <= br;
      req_chan.b_im  <= bi;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // receiver: random stalls, plus one long hold-off to back up the pipeline
   initial begin
      int gap;
      rsp_chan.ready <= 1'b0;
      @(negedge reset);
      repeat (300) begin
         gap = idle_len();
         rsp_chan.ready <= (gap == 0);
         @(posedge clock);
      end
      rsp_chan.ready <= 1'b0;
      repeat (200) @(posedge clock);
      forever begin
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         gap = idle_len();
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // stimulus
   initial begin
      logic [OP_W-1:0] op;
      logic signed [DATA_WIDTH-1:0] ar, ai, br, bi;
      int k;
      sending_done = 1'b0;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.op <= OP_ADD;
      req_chan.a_re <= '0;
      req_chan.a_im <= '0;
      req_chan.b_re <= '0;
      req_chan.b_im <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners
      send(OP_ADD, VMAX, VMIN, VMAX, VMIN);
      send(OP_ADD, 16'sd100, -16'sd200, 16'sd5, 16'sd7);
      send(OP_SUB, VMIN, VMAX, VMAX, VMIN);
      send(OP_SUB, 16'sd4096, 16'sd0, 16'sd1, -16'sd1);
      send(OP_MUL, VMIN, VMIN, VMIN, VMIN);
      send(OP_MUL, VMAX, VMAX, VMAX, VMIN);
      send(OP_MUL, 16'sd4096, 16'sd2048, -16'sd3, 16'sd1);
      send(OP_DIV, 16'sd4096, 16'sd4096, 16'sd0, 16'sd0);
      send(OP_DIV, VMAX, VMIN, 16'sd1, 16'sd0);
      send(OP_DIV, 16'sd4096, -16'sd2048, 16'sd8192, 16'sd4096);
      send(OP_DIV, VMIN, VMIN, VMIN, VMIN);
      send(OP_DIV, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send(OP_MOD, VMIN, VMIN, 16'sd0, 16'sd0);
      send(OP_MOD, 16'sd0, 16'sd0, VMAX, VMAX);
      send(OP_MOD, 16'sd3, -16'sd4, 16'sd0, 16'sd0);
      send(OP_ARG, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send(OP_ARG, 16'sd500, 16'sd0, 16'sd0, 16'sd0);
      send(OP_ARG, VMIN, 16'sd0, 16'sd0, 16'sd0);
      send(OP_ARG, -16'sd1, 16'sd1, 16'sd0, 16'sd0);
      send(OP_ARG, -16'sd1, -16'sd1, 16'sd0, 16'sd0);
      send(OP_ARG, 16'sd0, VMIN, 16'sd0, 16'sd0);
      send(OP_SPARE_LO, VMAX, VMIN, VMAX, VMIN);
      send(OP_SPARE_HI, -16'sd1, -16'sd1, -16'sd1, -16'sd1);

      // random operations, operands mixed from corners and full range
      repeat (1600) begin
         k = $urandom_range(0, 31);
         op = (k == 0) ? OP_SPARE_LO : (k == 1) ? OP_SPARE_HI
                                                : 3'($urandom_range(0, 5));
         ar = pick_operand();
         ai = pick_operand();
         br = pick_operand();
         bi = pick_operand();
         if ($urandom_range(0, 9) == 0) begin
            br = '0;
            bi = '0;
         end
         if ($urandom_range(0, 9) == 0) ai = '0;
         send(op, ar, ai, br, bi);
      end
      req_chan.valid <= 1'b0;
      sending_done = 1'b1;
   end

   // verdict
   initial begin
      wait (sending_done);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("checked %0d results, %0d saturating, %0d divide by zero",
               checked_count, sat_count, dz_count);
      if (fail_count == 0 && pending == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // watchdog
   initial begin
      #1000000;
      $display("timeout with %0d results outstanding", pending);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
